>>> sv/eabu_pkg.sv
// Shared types, constants and the pair blend function for the depth upscaler.
`timescale 1ns / 1ps
package eabu_pkg;

  localparam int SRC_SIDE_DEF   = 100;
  localparam int OUT_WIDTH_DEF  = 640;
  localparam int OUT_HEIGHT_DEF = 480;

  localparam int DEPTH_W = 16;
  localparam int ADDR_W  = 16;
  localparam int OFF_W   = 16;
  localparam int FRAC_W  = 9;
  localparam int QDEPTH  = 4;

  localparam logic [DEPTH_W-1:0] NO_DEPTH   = 16'hFFFF;
  localparam logic [DEPTH_W-1:0] JUMP_RESET = 16'd406;
  localparam logic [FRAC_W-1:0]  HALF_MIX   = 9'd128;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_HORIZ = 1'b0,
    CFG_VERT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] off;
    logic [FRAC_W-1:0]       frac;
  } samp_t;

  typedef struct packed {
    op_t                op;
    logic               ok;
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] depth;
    logic [FRAC_W-1:0]  hf;
    logic [FRAC_W-1:0]  vf;
  } qent_t;

  function automatic logic [DEPTH_W-1:0] mix_pair(
    input logic [DEPTH_W-1:0] a,
    input logic [DEPTH_W-1:0] b,
    input logic [FRAC_W-1:0]  f,
    input logic [DEPTH_W-1:0] lim
  );
    logic signed [16:0] d;
    logic [16:0]        mag;
    logic signed [26:0] p;
    logic signed [26:0] v;
    logic [DEPTH_W-1:0] r;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    mag = (d < 0) ? 17'(-d) : 17'(d);
    p   = $signed({1'b0, f}) * d;
    v   = $signed({3'b000, a, 8'h00}) + p;
    if (mag < {1'b0, lim}) begin
      r = (v < 0) ? '0 : v[23:8];
    end else begin
      r = (f >= HALF_MIX) ? b : a;
    end
    return r;
  endfunction

endpackage

>>> sv/eabu_front.sv
// Front end: accepts items, looks up sample tables and classifies loads and requests.
`timescale 1ns / 1ps
module eabu_front #(
  parameter int SRC_SIDE   = eabu_pkg::SRC_SIDE_DEF,
  parameter int OUT_WIDTH  = eabu_pkg::OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = eabu_pkg::OUT_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_operation,
  input  logic [13:0]         in_load_index,
  input  logic [15:0]         in_load_depth,
  input  logic [8:0]          in_out_row,
  input  logic [9:0]          in_out_col,
  output logic                push,
  output eabu_pkg::qent_t     push_ent
);
  import eabu_pkg::*;

  localparam int ROW_AW = $clog2(OUT_HEIGHT);
  localparam int COL_AW = $clog2(OUT_WIDTH);
  localparam int LINE_W = $clog2(SRC_SIDE);
  localparam int DEN    = 2 * OUT_HEIGHT;
  localparam int BASE   = (SRC_SIDE - 1) * OUT_HEIGHT;

  samp_t row_rom [OUT_HEIGHT];
  samp_t col_rom [OUT_WIDTH];

  for (genvar k = 0; k < OUT_HEIGHT; k++) begin : g_row
    localparam int NUM = BASE + SRC_SIDE * (OUT_HEIGHT - 1 - 2 * k);
    localparam int IP  = NUM / DEN;
    localparam int R   = NUM - IP * DEN;
    localparam int FR  = (IP <= 0 || IP >= SRC_SIDE - 1) ? 0 : (512 * R + DEN) / (2 * DEN);
    assign row_rom[k] = '{off: OFF_W'(IP), frac: FRAC_W'(FR)};
  end

  for (genvar k = 0; k < OUT_WIDTH; k++) begin : g_col
    localparam int NUM = BASE + SRC_SIDE * (OUT_WIDTH - 1 - 2 * k);
    localparam int IP  = NUM / DEN;
    localparam int R   = NUM - IP * DEN;
    localparam int FR  = (IP <= 0 || IP >= SRC_SIDE - 1) ? 0 : (512 * R + DEN) / (2 * DEN);
    assign col_rom[k] = '{off: OFF_W'(IP), frac: FRAC_W'(FR)};
  end

  logic               v1_r;
  op_t                op1_r;
  logic [13:0]        lidx1_r;
  logic [15:0]        ldep1_r;
  logic               inimg1_r;
  samp_t              rs_r;
  samp_t              cs_r;
  logic               row_in;
  logic               col_in;
  logic [ROW_AW-1:0]  ridx;
  logic [COL_AW-1:0]  cidx;
  logic               col_ok;
  logic               line_ok;
  logic [ADDR_W-1:0]  ref_addr;

  assign row_in = 32'(in_out_row) < OUT_HEIGHT;
  assign col_in = 32'(in_out_col) < OUT_WIDTH;
  assign ridx   = row_in ? ROW_AW'(in_out_row) : '0;
  assign cidx   = col_in ? COL_AW'(in_out_col) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op1_r    <= op_t'(in_operation);
    lidx1_r  <= in_load_index;
    ldep1_r  <= in_load_depth;
    inimg1_r <= row_in && col_in;
    rs_r     <= row_rom[ridx];
    cs_r     <= col_rom[cidx];
  end

  assign col_ok   = (rs_r.off >= 0) && (rs_r.off < SRC_SIDE);
  assign line_ok  = (cs_r.off >= 0) && (cs_r.off < SRC_SIDE);
  assign ref_addr = ADDR_W'(cs_r.off[LINE_W-1:0]) * ADDR_W'(SRC_SIDE)
                  + ADDR_W'(rs_r.off[LINE_W-1:0]);

  always_comb begin
    push_ent.op    = op1_r;
    push_ent.depth = ldep1_r;
    case (op1_r)
      OP_LOAD: begin
        push_ent.ok   = 32'(lidx1_r) < SRC_SIDE * SRC_SIDE;
        push_ent.addr = ADDR_W'(lidx1_r);
        push_ent.hf   = '0;
        push_ent.vf   = '0;
      end
      OP_REQ: begin
        push_ent.ok   = inimg1_r && col_ok && line_ok;
        push_ent.addr = ref_addr;
        push_ent.hf   = rs_r.frac;
        push_ent.vf   = cs_r.frac;
      end
      default: begin
        push_ent.ok   = 1'b0;
        push_ent.addr = '0;
        push_ent.hf   = '0;
        push_ent.vf   = '0;
      end
    endcase
  end

  assign push = v1_r;

endmodule

>>> sv/eabu_queue.sv
// Short queue between front and back ends.
`timescale 1ns / 1ps
module eabu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  eabu_pkg::qent_t  push_ent,
  output logic             pop,
  output eabu_pkg::qent_t  pop_ent,
  output logic             busy
);
  import eabu_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t             slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_r;
  logic [PTR_W-1:0]  rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              full;

  assign pop     = cnt_r != '0;
  assign pop_ent = slot_r[rd_r];
  assign full    = cnt_r == CNT_W'(QDEPTH);
  // leave room for the beat still in the front register
  assign busy    = cnt_r >= CNT_W'(QDEPTH - 2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue overflow");

endmodule

>>> sv/eabu_back.sv
// Back end: frame memories, quad fetch and two-level edge-aware blend.
`timescale 1ns / 1ps
module eabu_back #(
  parameter int SRC_SIDE = eabu_pkg::SRC_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop,
  input  eabu_pkg::qent_t  pop_ent,
  input  logic [15:0]      horiz_lim,
  input  logic [15:0]      vert_lim,
  output logic             out_strobe,
  output logic [15:0]      out_depth
);
  import eabu_pkg::*;

  localparam int NPIX = SRC_SIDE * SRC_SIDE;
  localparam int AW   = $clog2(NPIX);

  logic [DEPTH_W-1:0] mem_sw [NPIX];
  logic [DEPTH_W-1:0] mem_se [NPIX];
  logic [DEPTH_W-1:0] mem_nw [NPIX];
  logic [DEPTH_W-1:0] mem_ne [NPIX];

  logic [AW-1:0]      a_sw;
  logic [AW-1:0]      a_se;
  logic [AW-1:0]      a_nw;
  logic [AW-1:0]      a_ne;
  logic               wr_en;

  logic               v1_r;
  logic               ok1_r;
  logic [FRAC_W-1:0]  hf1_r;
  logic [FRAC_W-1:0]  vf1_r;
  logic [DEPTH_W-1:0] sw1_r;
  logic [DEPTH_W-1:0] se1_r;
  logic [DEPTH_W-1:0] nw1_r;
  logic [DEPTH_W-1:0] ne1_r;

  logic               v2_r;
  logic               bad2_r;
  logic [FRAC_W-1:0]  vf2_r;
  logic [DEPTH_W-1:0] bot2_r;
  logic [DEPTH_W-1:0] top2_r;

  logic               strobe_r;
  logic [DEPTH_W-1:0] depth_r;

  logic               hon;
  logic               von;
  logic               inv1;

  assign a_sw  = pop_ent.addr[AW-1:0];
  assign a_se  = AW'(pop_ent.addr + 1'b1);
  assign a_nw  = AW'(pop_ent.addr + ADDR_W'(SRC_SIDE));
  assign a_ne  = AW'(pop_ent.addr + ADDR_W'(SRC_SIDE + 1));
  assign wr_en = pop && (pop_ent.op == OP_LOAD) && pop_ent.ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_sw[a_sw] <= pop_ent.depth;
      mem_se[a_sw] <= pop_ent.depth;
      mem_nw[a_sw] <= pop_ent.depth;
      mem_ne[a_sw] <= pop_ent.depth;
    end
    sw1_r <= mem_sw[a_sw];
    se1_r <= mem_se[a_se];
    nw1_r <= mem_nw[a_nw];
    ne1_r <= mem_ne[a_ne];
  end

  assign hon  = hf1_r != '0;
  assign von  = vf1_r != '0;
  assign inv1 = (sw1_r == NO_DEPTH)
             || (hon && (se1_r == NO_DEPTH))
             || (von && (nw1_r == NO_DEPTH))
             || (von && hon && (ne1_r == NO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      v1_r     <= pop && (pop_ent.op == OP_REQ);
      v2_r     <= v1_r;
      strobe_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ok1_r  <= pop_ent.ok;
    hf1_r  <= pop_ent.hf;
    vf1_r  <= pop_ent.vf;
    bad2_r <= !ok1_r || inv1;
    vf2_r  <= vf1_r;
    bot2_r <= hon ? mix_pair(sw1_r, se1_r, hf1_r, horiz_lim) : sw1_r;
    top2_r <= hon ? mix_pair(nw1_r, ne1_r, hf1_r, horiz_lim) : nw1_r;
    if (bad2_r) begin
      depth_r <= NO_DEPTH;
    end else if (vf2_r != '0) begin
      depth_r <= mix_pair(bot2_r, top2_r, vf2_r, vert_lim);
    end else begin
      depth_r <= bot2_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_depth  = depth_r;

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_ent.op == OP_REQ) |-> ##3 out_strobe)
    else $error("request beat lost");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_ent.op == OP_LOAD) |-> ##3 !out_strobe)
    else $error("load produced a result");

endmodule

>>> sv/edge_aware_bilinear_upscaler.sv
// Top level of the edge-aware bilinear depth upscaler.
`timescale 1ns / 1ps
// Takes one beat per clock while busy is low, load or request alike; busy stays
// low in steady use because the back end drains one queue entry every cycle.
// Each request strobes its result, in request order, after the front register,
// queue slot, memory read, horizontal blend and vertical blend registers; loads
// return nothing. The rate is set by four replicated frame memories, each with one
// write and one registered read port, so all four quad pixels come out together.
// Results cannot be held off: capture out_depth whenever out_strobe is high.
module edge_aware_bilinear_upscaler #(
  parameter int SRC_SIDE   = eabu_pkg::SRC_SIDE_DEF,
  parameter int OUT_WIDTH  = eabu_pkg::OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = eabu_pkg::OUT_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [13:0] in_load_index,
  input  logic [15:0] in_load_depth,
  input  logic [8:0]  in_out_row,
  input  logic [9:0]  in_out_col,
  output logic        out_strobe,
  output logic [15:0] out_depth,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import eabu_pkg::*;

  logic [15:0] hlim_r;
  logic [15:0] vlim_r;
  logic        push;
  qent_t       push_ent;
  logic        pop;
  qent_t       pop_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlim_r <= JUMP_RESET;
      vlim_r <= JUMP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HORIZ: hlim_r <= cfg_data;
        CFG_VERT:  vlim_r <= cfg_data;
        default:   hlim_r <= hlim_r;
      endcase
    end
  end

  eabu_front #(
    .SRC_SIDE   (SRC_SIDE),
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_load_index (in_load_index),
    .in_load_depth (in_load_depth),
    .in_out_row    (in_out_row),
    .in_out_col    (in_out_col),
    .push          (push),
    .push_ent      (push_ent)
  );

  eabu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .pop_ent  (pop_ent),
    .busy     (busy)
  );

  eabu_back #(
    .SRC_SIDE (SRC_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_ent    (pop_ent),
    .horiz_lim  (hlim_r),
    .vert_lim   (vlim_r),
    .out_strobe (out_strobe),
    .out_depth  (out_depth)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the edge-aware bilinear depth upscaler.
`timescale 1ns / 1ps
module testbench;
  import eabu_pkg::*;

  localparam int SIDE   = 100;
  localparam int OW     = 640;
  localparam int OH     = 480;
  localparam int NPIX   = SIDE * SIDE;
  localparam int PERIOD = 12;

  typedef struct {
    op_t         op;
    logic [13:0] idx;
    logic [15:0] depth;
    logic [8:0]  row;
    logic [9:0]  col;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [13:0] in_load_index = '0;
  logic [15:0] in_load_depth = '0;
  logic [8:0]  in_out_row = '0;
  logic [9:0]  in_out_col = '0;
  logic        out_strobe;
  logic [15:0] out_depth;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  logic [15:0] frame_model [NPIX];
  int          row_off [OH];
  int          row_frac [OH];
  int          col_off [OW];
  int          col_frac [OW];
  logic [15:0] horiz_lim = JUMP_RESET;
  logic [15:0] vert_lim = JUMP_RESET;
  logic [15:0] depth_expected [$];
  int          fails = 0;
  bit          quiet = 1'b0;
  bit          pend_typed = 1'b0;
  logic [15:0] pend_want = '0;

  edge_aware_bilinear_upscaler u_dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_load_index, .in_load_depth,
    .in_out_row, .in_out_col, .out_strobe, .out_depth, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  initial begin
    #(PERIOD * 600000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void build_samples(input int num, output int off, output int frac);
    int den;
    int r;
    den = 2 * OH;
    off = num / den;
    if (off <= 0 || off >= SIDE - 1) begin
      frac = 0;
    end else begin
      r = num - off * den;
      frac = (512 * r + den) / (2 * den);
    end
  endfunction

  function automatic int blend(input int a, input int b, input int f, input int lim);
    int d;
    int mag;
    int v;
    d = b - a;
    mag = (d < 0) ? -d : d;
    if (mag < lim) begin
      v = a * 256 + f * d;
      if (v < 0) v = 0;
      return (v >>> 8) & 16'hFFFF;
    end
    return (f >= 128) ? b : a;
  endfunction

  function automatic logic [15:0] predict_depth(input int row, input int col);
    int i, hf, vf, base, sw, se, nw, ne, bot, top;
    if (row >= OH || col >= OW) return NO_DEPTH;
    i = row_off[row];
    if (i < 0 || i >= SIDE) return NO_DEPTH;
    hf = row_frac[row];
    base = col_off[col] + i;
    if (base < 0 || base >= NPIX) return NO_DEPTH;
    vf = col_frac[col];
    sw = frame_model[base];
    if (sw == NO_DEPTH) return NO_DEPTH;
    bot = sw;
    if (hf > 0) begin
      se = frame_model[base + 1];
      if (se == NO_DEPTH) return NO_DEPTH;
      bot = blend(sw, se, hf, horiz_lim);
    end
    if (vf <= 0) return bot;
    nw = frame_model[base + SIDE];
    if (nw == NO_DEPTH) return NO_DEPTH;
    top = nw;
    if (hf > 0) begin
      ne = frame_model[base + SIDE + 1];
      if (ne == NO_DEPTH) return NO_DEPTH;
      top = blend(nw, ne, hf, horiz_lim);
    end
    return blend(bot, top, vf, vert_lim);
  endfunction

  function automatic bit reads_loaded(input int row, input int col);
    int i, hf, vf, base;
    if (row >= OH || col >= OW) return 1'b1;
    i = row_off[row];
    if (i < 0 || i >= SIDE) return 1'b1;
    hf = row_frac[row];
    base = col_off[col] + i;
    if (base < 0 || base >= NPIX) return 1'b1;
    vf = col_frac[col];
    if ($isunknown(frame_model[base])) return 1'b0;
    if (hf > 0 && $isunknown(frame_model[base + 1])) return 1'b0;
    if (vf > 0 && $isunknown(frame_model[base + SIDE])) return 1'b0;
    if (hf > 0 && vf > 0 && $isunknown(frame_model[base + SIDE + 1])) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int o, f;
    for (int k = 0; k < OH; k++) begin
      build_samples((SIDE - 1) * OH + SIDE * (OH - 1 - 2 * k), o, f);
      row_off[k] = o;
      row_frac[k] = f;
    end
    for (int k = 0; k < OW; k++) begin
      build_samples((SIDE - 1) * OH + SIDE * (OW - 1 - 2 * k), o, f);
      col_off[k] = o * SIDE;
      col_frac[k] = f;
    end
  end

  always @(posedge clk) begin
    logic [15:0] p;
    if (rst_n && start && !busy) begin
      if (in_operation == OP_LOAD) begin
        if (in_load_index < NPIX) frame_model[in_load_index] = in_load_depth;
      end else begin
        p = predict_depth(in_out_row, in_out_col);
        if (pend_typed && p != pend_want) begin
          $display("%0t predictor disagrees with table: table %h predictor %h",
                   $time, pend_want, p);
          fails++;
        end
        depth_expected.push_back(pend_typed ? pend_want : p);
      end
    end
    if (rst_n && out_strobe) begin
      if (depth_expected.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_depth);
        fails++;
      end else begin
        p = depth_expected.pop_front();
        if (out_depth !== p) begin
          $display("%0t out_depth mismatch: expected %h actual %h", $time, p, out_depth);
          fails++;
        end
      end
    end
  end

  task automatic send_beat(input op_t op, input logic [13:0] idx, input logic [15:0] dep,
                           input logic [8:0] row, input logic [9:0] col,
                           input bit typed, input logic [15:0] want);
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_load_index <= idx;
    in_load_depth <= dep;
    in_out_row <= row;
    in_out_col <= col;
    pend_typed <= typed;
    pend_want <= want;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic maybe_idle();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 18);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (depth_expected.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_limit(input cfg_idx_t which, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    if (which == CFG_HORIZ) horiz_lim = val;
    else vert_lim = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    logic [8:0] r;
    logic [9:0] c;
    int tries;
    tries = 0;
    do begin
      if ($urandom_range(0, 9) == 0) begin
        r = 9'($urandom_range(0, 511));
        c = 10'($urandom_range(0, 1023));
      end else begin
        r = 9'($urandom_range(0, OH - 1));
        c = 10'($urandom_range(300, 340));
      end
      tries++;
    end while (!reads_loaded(r, c) && tries < 100);
    if (!reads_loaded(r, c)) r = 9'(OH);
    send_beat(OP_REQ, 14'($urandom), 16'($urandom), r, c, 1'b0, '0);
  endtask

  task automatic random_load();
    logic [13:0] idx;
    logic [15:0] d;
    idx = ($urandom_range(0, 19) == 0) ? 14'($urandom) : 14'($urandom_range(0, NPIX - 1));
    case ($urandom_range(0, 9))
      0: d = NO_DEPTH;
      1: d = 16'($urandom);
      default: d = 16'($urandom_range(500, 4000));
    endcase
    send_beat(OP_LOAD, idx, d, 9'($urandom), 10'($urandom), 1'b0, '0);
  endtask

  stim_row_t plan [] = '{
    '{OP_LOAD, 14'd0,     16'h0000, 9'd0,   10'd0,   1'b0, 16'h0},
    '{OP_LOAD, 14'd9999,  16'hFFFF, 9'd0,   10'd0,   1'b0, 16'h0},
    '{OP_LOAD, 14'd16383, 16'h1234, 9'd0,   10'd0,   1'b0, 16'h0},
    '{OP_LOAD, 14'd10000, 16'h4321, 9'd0,   10'd0,   1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd480, 10'd0,   1'b1, 16'hFFFF},
    '{OP_REQ,  14'd0,     16'h0,    9'd0,   10'd640, 1'b1, 16'hFFFF},
    '{OP_REQ,  14'd0,     16'h0,    9'd511, 10'd1023, 1'b1, 16'hFFFF},
    '{OP_REQ,  14'd0,     16'h0,    9'd0,   10'd0,   1'b1, 16'hFFFF},
    '{OP_REQ,  14'd0,     16'h0,    9'd479, 10'd639, 1'b1, 16'hFFFF},
    '{OP_REQ,  14'd0,     16'h0,    9'd0,   10'd320, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd479, 10'd320, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd240, 10'd320, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd241, 10'd321, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd17,  10'd310, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd463, 10'd325, 1'b0, 16'h0},
    '{OP_REQ,  14'd0,     16'h0,    9'd100, 10'd330, 1'b0, 16'h0}
  };

  initial begin
    logic [15:0] patch;
    logic [15:0] limits [5] = '{16'd0, 16'd65535, 16'd1, 16'd406, 16'd406};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // preload a band of lines: patches of similar depth with jumps between
    for (int a = 47 * SIDE; a < 53 * SIDE; a++) begin
      if (a % 7 == 0) patch = 16'($urandom_range(0, 6000));
      case ($urandom_range(0, 24))
        0: send_beat(OP_LOAD, 14'(a), NO_DEPTH, '0, '0, 1'b0, '0);
        1: send_beat(OP_LOAD, 14'(a), 16'($urandom_range(0, 65534)), '0, '0, 1'b0, '0);
        default: send_beat(OP_LOAD, 14'(a), patch + 16'($urandom_range(0, 300)), '0, '0,
                           1'b0, '0);
      endcase
    end

    foreach (plan[n]) begin
      send_beat(plan[n].op, plan[n].idx, plan[n].depth, plan[n].row, plan[n].col,
                plan[n].typed, plan[n].want);
      maybe_idle();
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(CFG_HORIZ, (ph == 4) ? 16'($urandom_range(50, 2000)) : limits[ph]);
      write_limit(CFG_VERT, (ph == 4) ? 16'($urandom_range(50, 2000)) : limits[(ph + 2) % 5]);
      quiet = (ph == 4);
      for (int n = 0; n < 220; n++) begin
        if ($urandom_range(0, 9) < 7) random_request();
        else random_load();
        maybe_idle();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
